// ===== sv/weighted_median_mae_tracker_assert.svh =====
// Assertion macros for the weighted median tracker checks.
`ifndef WEIGHTED_MEDIAN_MAE_TRACKER_ASSERT_SVH
`define WEIGHTED_MEDIAN_MAE_TRACKER_ASSERT_SVH

// same-cycle implication, off during reset
`define WMM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("wmm check failed");

// next-cycle implication, off during reset
`define WMM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("wmm check failed");

// next-cycle implication, active during reset
`define WMM_ASSERT_RST(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("wmm reset check failed");

`endif

// ===== sv/wmm_pkg.sv =====
// Shared types and constants of the weighted median tracker.
package wmm_pkg;

    localparam int CAPACITY_DEF = 256;
    localparam int KEY_W        = 24;
    localparam int WT_W         = 16;
    localparam int EW_W         = 24;
    localparam int MED_W        = 25;
    localparam int MAD_W        = 32;
    localparam int ST_W         = 2;
    localparam int MAD_FRAC     = 7;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

    localparam logic [EW_W-1:0] ENTRY_WT_MAX = {EW_W{1'b1}};

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_ERASE  = 1'b1;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_S_RD,
        OP_S_EX,
        OP_DECIDE,
        OP_I_RD,
        OP_I_WR,
        OP_X_RD,
        OP_X_WR,
        OP_M_INIT,
        OP_M_RD,
        OP_M_EX,
        OP_D_RD,
        OP_D_MUL,
        OP_D_ACC,
        OP_V_INIT,
        OP_V_STEP,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic in_ready;
    } t_cmd;

    typedef struct packed {
        logic idx_end;
        logic key_ge;
        logic need_ins;
        logic need_del;
        logic idx_eq_pos;
        logic idx_last;
        logic tot_zero;
        logic med_hit;
        logic div_last;
        logic out_free;
    } t_stat;

endpackage

// ===== sv/wmm_in_if.sv =====
// Input channel of the weighted median tracker.
interface wmm_in_if;
    import wmm_pkg::*;

    logic             valid;
    logic             ready;
    logic             action;
    logic [KEY_W-1:0] key_value;
    logic [WT_W-1:0]  weight;

    modport source (output valid, output action, output key_value, output weight,
                    input ready);
    modport sink   (input valid, input action, input key_value, input weight,
                    output ready);
endinterface

// ===== sv/wmm_out_if.sv =====
// Result channel of the weighted median tracker.
interface wmm_out_if;
    import wmm_pkg::*;

    logic             valid;
    logic             ready;
    logic [MED_W-1:0] median_half_units;
    logic [MAD_W-1:0] mean_abs_dev;
    logic [EW_W-1:0]  total_weight;
    logic [ST_W-1:0]  status;

    modport source (output valid, output median_half_units, output mean_abs_dev,
                    output total_weight, output status, input ready);
    modport sink   (input valid, input median_half_units, input mean_abs_dev,
                    input total_weight, input status, output ready);
endinterface

// ===== sv/wmm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module wmm_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/wmm_ctrl.sv =====
// Sequencing state machine of the weighted median tracker.
module wmm_ctrl import wmm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    typedef enum logic [4:0] {
        S_IDLE, S_SRD, S_SEX, S_DEC, S_IRD, S_IWR, S_XRD, S_XWR,
        S_MINIT, S_MRD, S_MEX, S_DRD, S_DMUL, S_DACC, S_VINIT, S_VSTEP, S_OUT
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd.op       = OP_NONE;
        o_cmd.in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_SRD;
                end
            end
            S_SRD: begin
                o_cmd.op = OP_S_RD;
                n_state  = i_stat.idx_end ? S_DEC : S_SEX;
            end
            S_SEX: begin
                o_cmd.op = OP_S_EX;
                n_state  = i_stat.key_ge ? S_DEC : S_SRD;
            end
            S_DEC: begin
                o_cmd.op = OP_DECIDE;
                priority if (i_stat.need_ins) n_state = S_IRD;
                else if (i_stat.need_del)     n_state = S_XRD;
                else                          n_state = S_MINIT;
            end
            S_IRD: begin
                o_cmd.op = OP_I_RD;
                n_state  = i_stat.idx_eq_pos ? S_MINIT : S_IWR;
            end
            S_IWR: begin
                o_cmd.op = OP_I_WR;
                n_state  = S_IRD;
            end
            S_XRD: begin
                o_cmd.op = OP_X_RD;
                n_state  = i_stat.idx_last ? S_MINIT : S_XWR;
            end
            S_XWR: begin
                o_cmd.op = OP_X_WR;
                n_state  = S_XRD;
            end
            S_MINIT: begin
                o_cmd.op = OP_M_INIT;
                n_state  = i_stat.tot_zero ? S_OUT : S_MRD;
            end
            S_MRD: begin
                o_cmd.op = OP_M_RD;
                n_state  = S_MEX;
            end
            S_MEX: begin
                o_cmd.op = OP_M_EX;
                n_state  = i_stat.med_hit ? S_DRD : S_MRD;
            end
            S_DRD: begin
                o_cmd.op = OP_D_RD;
                n_state  = i_stat.idx_end ? S_VINIT : S_DMUL;
            end
            S_DMUL: begin
                o_cmd.op = OP_D_MUL;
                n_state  = S_DACC;
            end
            S_DACC: begin
                o_cmd.op = OP_D_ACC;
                n_state  = S_DRD;
            end
            S_VINIT: begin
                o_cmd.op = OP_V_INIT;
                n_state  = S_VSTEP;
            end
            S_VSTEP: begin
                o_cmd.op = OP_V_STEP;
                n_state  = i_stat.div_last ? S_OUT : S_VSTEP;
            end
            S_OUT: begin
                o_cmd.op = OP_OUT;
                n_state  = i_stat.out_free ? S_IDLE : S_OUT;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// ===== sv/wmm_dp.sv =====
// Datapath of the weighted median tracker: table RAM, sums, divider, result register.
module wmm_dp import wmm_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    output t_stat     o_stat,
    wmm_in_if.sink    i_in,
    wmm_out_if.source o_out
);
    localparam int AW    = $clog2(CAPACITY);
    localparam int IW    = $clog2(CAPACITY + 1);
    localparam int TW    = EW_W + IW;
    localparam int PW    = MED_W + EW_W;
    localparam int SW    = PW + IW;
    localparam int DW    = SW + MAD_FRAC;
    localparam int CW    = $clog2(DW + 1);
    localparam int RAM_W = KEY_W + EW_W;

    logic                    r_act;
    logic signed [KEY_W-1:0] r_key;
    logic [WT_W-1:0]         r_w;
    logic [IW-1:0]           r_idx, r_pos, r_cnt;
    logic                    r_found;
    logic [EW_W-1:0]         r_ew;
    logic [TW-1:0]           r_total, r_cum;
    logic [ST_W-1:0]         r_status;
    logic signed [KEY_W-1:0] r_prev;
    logic [MED_W-1:0]        r_med;
    logic [PW-1:0]           r_prod;
    logic [SW-1:0]           r_acc;
    logic [DW-1:0]           r_dvd;
    logic [TW-1:0]           r_rem;
    logic [MAD_W-1:0]        r_quo;
    logic                    r_ovf;
    logic [CW-1:0]           r_dcnt;
    logic                    r_ovld;
    logic [MED_W-1:0]        r_o_med;
    logic [MAD_W-1:0]        r_o_mad;
    logic [EW_W-1:0]         r_o_tot;
    logic [ST_W-1:0]         r_o_st;

    logic                    we;
    logic [AW-1:0]           waddr, raddr;
    logic [RAM_W-1:0]        wdata, rdata;
    logic signed [KEY_W-1:0] rkey;
    logic [EW_W-1:0]         rw;
    logic [EW_W:0]           wsum;
    logic [EW_W-1:0]         wsat;
    logic                    w_nz;
    logic [TW-1:0]           cum_n;
    logic [MED_W:0]          dev;
    logic [MED_W-1:0]        adev;
    logic [TW:0]             rem2;
    logic                    qbit;

    wmm_ram #(.WIDTH(RAM_W), .DEPTH(CAPACITY)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign rkey  = rdata[RAM_W-1:EW_W];
    assign rw    = rdata[EW_W-1:0];
    assign w_nz  = (r_w != '0);
    assign wsum  = {1'b0, r_ew} + (EW_W+1)'(r_w);
    assign wsat  = wsum[EW_W] ? ENTRY_WT_MAX : wsum[EW_W-1:0];
    assign cum_n = r_cum + TW'(rw);
    assign dev   = {rkey[KEY_W-1], rkey, 1'b0} - {r_med[MED_W-1], r_med};
    assign adev  = dev[MED_W] ? MED_W'(-dev) : dev[MED_W-1:0];
    assign rem2  = {r_rem, r_dvd[DW-1]};
    assign qbit  = (rem2 >= {1'b0, r_total});

    always_comb begin
        o_stat.idx_end    = (r_idx == r_cnt);
        o_stat.key_ge     = (rkey >= r_key);
        o_stat.need_ins   = w_nz && (r_act == ACT_INSERT) && !r_found
                            && (r_cnt < IW'(CAPACITY));
        o_stat.need_del   = w_nz && (r_act == ACT_ERASE) && r_found
                            && (EW_W'(r_w) == r_ew);
        o_stat.idx_eq_pos = (r_idx == r_pos);
        o_stat.idx_last   = (IW'(r_idx + IW'(1)) == r_cnt);
        o_stat.tot_zero   = (r_total == '0);
        o_stat.med_hit    = ({cum_n, 1'b0} > {1'b0, r_total});
        o_stat.div_last   = (r_dcnt == CW'(1));
        o_stat.out_free   = !r_ovld || o_out.ready;
    end

    always_comb begin
        we    = 1'b0;
        waddr = r_idx[AW-1:0];
        wdata = rdata;
        unique case (i_cmd.op)
            OP_I_RD: raddr = AW'(r_idx - IW'(1));
            OP_X_RD: raddr = AW'(r_idx + IW'(1));
            default: raddr = r_idx[AW-1:0];
        endcase
        unique case (i_cmd.op)
            OP_DECIDE: begin
                waddr = r_pos[AW-1:0];
                if (w_nz && r_found) begin
                    if (r_act == ACT_INSERT) begin
                        we    = 1'b1;
                        wdata = {r_key, wsat};
                    end else if (EW_W'(r_w) < r_ew) begin
                        we    = 1'b1;
                        wdata = {r_key, r_ew - EW_W'(r_w)};
                    end
                end
            end
            OP_I_RD: begin
                waddr = r_pos[AW-1:0];
                wdata = {r_key, EW_W'(r_w)};
                we    = o_stat.idx_eq_pos;
            end
            OP_I_WR, OP_X_WR: we = 1'b1;
            default: we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_total <= '0;
            r_ovld  <= 1'b0;
        end else begin
            if (i_cmd.op == OP_OUT && o_stat.out_free) begin
                r_ovld <= 1'b1;
            end else if (r_ovld && o_out.ready) begin
                r_ovld <= 1'b0;
            end
            unique case (i_cmd.op)
                OP_LOAD: begin
                    r_act    <= i_in.action;
                    r_key    <= i_in.key_value;
                    r_w      <= i_in.weight;
                    r_idx    <= '0;
                    r_pos    <= r_cnt;
                    r_found  <= 1'b0;
                    r_ew     <= '0;
                    r_status <= ST_OK;
                end
                OP_S_EX: begin
                    if (o_stat.key_ge) begin
                        r_pos   <= r_idx;
                        r_found <= (rkey == r_key);
                        r_ew    <= rw;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                OP_DECIDE: begin
                    if (w_nz) begin
                        if (r_act == ACT_INSERT) begin
                            if (r_found) begin
                                r_total <= r_total + TW'(wsat) - TW'(r_ew);
                            end else if (r_cnt >= IW'(CAPACITY)) begin
                                r_status <= ST_FULL;
                            end else begin
                                r_total <= r_total + TW'(r_w);
                                r_idx   <= r_cnt;
                            end
                        end else begin
                            if (!r_found) begin
                                r_status <= ST_NOT_FOUND;
                            end else if (EW_W'(r_w) > r_ew) begin
                                r_status <= ST_UNDERFLOW;
                            end else begin
                                r_total <= r_total - TW'(r_w);
                                r_idx   <= r_pos;
                            end
                        end
                    end
                end
                OP_I_RD: begin
                    if (o_stat.idx_eq_pos) begin
                        r_cnt <= r_cnt + IW'(1);
                    end
                end
                OP_I_WR: r_idx <= r_idx - IW'(1);
                OP_X_RD: begin
                    if (o_stat.idx_last) begin
                        r_cnt <= r_cnt - IW'(1);
                    end
                end
                OP_X_WR: r_idx <= r_idx + IW'(1);
                OP_M_INIT: begin
                    r_idx  <= '0;
                    r_cum  <= '0;
                    r_med  <= '0;
                    r_prev <= '0;
                    r_acc  <= '0;
                    r_quo  <= '0;
                    r_ovf  <= 1'b0;
                end
                OP_M_EX: begin
                    if (o_stat.med_hit) begin
                        if (r_idx != '0 && {r_cum, 1'b0} == {1'b0, r_total}) begin
                            r_med <= {r_prev[KEY_W-1], r_prev} + {rkey[KEY_W-1], rkey};
                        end else begin
                            r_med <= {rkey, 1'b0};
                        end
                        r_idx <= '0;
                    end else begin
                        r_prev <= rkey;
                        r_cum  <= cum_n;
                        r_idx  <= r_idx + IW'(1);
                    end
                end
                OP_D_MUL: r_prod <= PW'(adev) * PW'(rw);
                OP_D_ACC: begin
                    r_acc <= r_acc + SW'(r_prod);
                    r_idx <= r_idx + IW'(1);
                end
                OP_V_INIT: begin
                    r_dvd  <= {r_acc, MAD_FRAC'(0)};
                    r_rem  <= '0;
                    r_quo  <= '0;
                    r_ovf  <= 1'b0;
                    r_dcnt <= CW'(DW);
                end
                OP_V_STEP: begin
                    r_rem  <= qbit ? TW'(rem2 - {1'b0, r_total}) : rem2[TW-1:0];
                    r_dvd  <= {r_dvd[DW-2:0], 1'b0};
                    r_quo  <= {r_quo[MAD_W-2:0], qbit};
                    r_ovf  <= r_ovf | r_quo[MAD_W-1];
                    r_dcnt <= r_dcnt - CW'(1);
                end
                OP_OUT: begin
                    if (o_stat.out_free) begin
                        r_o_med <= r_med;
                        r_o_mad <= r_ovf ? {MAD_W{1'b1}} : r_quo;
                        r_o_tot <= (r_total > TW'(ENTRY_WT_MAX)) ? ENTRY_WT_MAX
                                                                 : r_total[EW_W-1:0];
                        r_o_st  <= r_status;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out.valid             = r_ovld;
    assign o_out.median_half_units = r_o_med;
    assign o_out.mean_abs_dev      = r_o_mad;
    assign o_out.total_weight      = r_o_tot;
    assign o_out.status            = r_o_st;
endmodule

// ===== sv/weighted_median_mae_tracker.sv =====
// Top level of the weighted median and mean absolute deviation tracker.
// One word is taken at a time. The table lives in a single-port-read RAM and is
// walked one entry at a time, each entry taking a read state and then an
// examine or write state for the key search, the insert or erase shift and the
// median scan, and a read, a multiply and an accumulate state for the
// deviation sum; a restoring divider then takes one quotient bit per cycle.
// The next word is accepted while a finished result still waits on the output register.
module weighted_median_mae_tracker import wmm_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wmm_in_if.sink    i_in,
    wmm_out_if.source o_out
);
    t_cmd  cmd;
    t_stat stat;

    assign i_in.ready = cmd.in_ready;

    wmm_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in.valid),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    wmm_dp #(.CAPACITY(CAPACITY)) u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd),
        .o_stat (stat),
        .i_in   (i_in),
        .o_out  (o_out)
    );
endmodule

// ===== sv/wmm_checker.sv =====
// Port-level checks of the weighted median tracker and their bind.
`include "weighted_median_mae_tracker_assert.svh"

module wmm_checker import wmm_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [MED_W-1:0] i_median,
    input logic [MAD_W-1:0] i_mad,
    input logic [EW_W-1:0]  i_total,
    input logic [ST_W-1:0]  i_status
);
    `WMM_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid)
    `WMM_ASSERT_NOW(a_empty_zero, i_out_valid && i_total == '0, i_median == '0 && i_mad == '0)
    `WMM_ASSERT_NOW(a_full_nonempty, i_out_valid && i_status == ST_FULL, i_total != '0)
    `WMM_ASSERT_RST(a_reset_idle, !i_rst_n, !i_out_valid)
endmodule

bind weighted_median_mae_tracker wmm_checker u_wmm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_median   (o_out.median_half_units),
    .i_mad      (o_out.mean_abs_dev),
    .i_total    (o_out.total_weight),
    .i_status   (o_out.status)
);
